### design/assert_macros.svh
// Assertion macros used by the detector top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SEKD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sekd assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SEKD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sekd assertion failed");

`endif

### design/sekd_pkg.sv
// ----------------------------------------------------------------------------
// sekd_pkg
// Types, widths and register indexes of the subpixel edge keyline detector.
// ----------------------------------------------------------------------------
package sekd_pkg;

	localparam int SUM_W  = 20;
	localparam int PROD_W = 40;
	localparam int D_W    = 37;
	localparam int DEN_W  = 39;
	localparam int REM_W  = 48;
	localparam int Q_W    = 8;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [2:0] REG_MAG_THR  = 3'd0;
	localparam logic [2:0] REG_GRAD_THR = 3'd1;
	localparam logic [2:0] REG_PN_LIM   = 3'd2;
	localparam logic [2:0] REG_KL_LIM   = 3'd3;
	localparam logic [2:0] REG_WIDTH    = 3'd4;

	typedef struct packed {
		logic [15:0] mag_min;
		logic [39:0] grad_threshold_sq;
		logic [3:0]  pn_limit;
		logic [15:0] keyline_limit;
		logic [12:0] image_width;
	} cfg_t;

	typedef struct packed {
		logic               start_of_frame;
		logic [15:0]        magnitude;
		logic signed [15:0] dog_up_left;
		logic signed [15:0] dog_up;
		logic signed [15:0] dog_up_right;
		logic signed [15:0] dog_left;
		logic signed [15:0] dog_center;
		logic signed [15:0] dog_right;
		logic signed [15:0] dog_down_left;
		logic signed [15:0] dog_down;
		logic signed [15:0] dog_down_right;
	} pix_t;

	typedef struct packed {
		logic               keyline_found;
		logic               limit_reached;
		logic [19:0]        pos_col_fx;
		logic [19:0]        pos_row_fx;
		logic signed [19:0] grad_x_sum;
		logic signed [19:0] grad_y_sum;
		logic [15:0]        keyline_index;
	} res_t;

	typedef struct packed {
		logic load;
		logic sums;
		logic mult;
		logic test;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic pass;
	} stat_t;

	function automatic logic signed [SUM_W-1:0] ext_sum(input logic signed [15:0] v);
		return {{(SUM_W-16){v[15]}}, v};
	endfunction

endpackage

### design/sekd_if.sv
// ----------------------------------------------------------------------------
// sekd_in_if
// Valid/ready channel carrying one pixel transaction.
// ----------------------------------------------------------------------------
interface sekd_in_if;
	logic               valid;
	logic               ready;
	logic               start_of_frame;
	logic [15:0]        magnitude;
	logic signed [15:0] dog_up_left;
	logic signed [15:0] dog_up;
	logic signed [15:0] dog_up_right;
	logic signed [15:0] dog_left;
	logic signed [15:0] dog_center;
	logic signed [15:0] dog_right;
	logic signed [15:0] dog_down_left;
	logic signed [15:0] dog_down;
	logic signed [15:0] dog_down_right;

	modport source (output valid, start_of_frame, magnitude, dog_up_left, dog_up,
		dog_up_right, dog_left, dog_center, dog_right, dog_down_left, dog_down,
		dog_down_right, input ready);
	modport sink (input valid, start_of_frame, magnitude, dog_up_left, dog_up,
		dog_up_right, dog_left, dog_center, dog_right, dog_down_left, dog_down,
		dog_down_right, output ready);
endinterface

// ----------------------------------------------------------------------------
// sekd_out_if
// Valid/ready channel carrying one result transaction.
// ----------------------------------------------------------------------------
interface sekd_out_if;
	logic               valid;
	logic               ready;
	logic               keyline_found;
	logic               limit_reached;
	logic [19:0]        pos_col_fx;
	logic [19:0]        pos_row_fx;
	logic signed [19:0] grad_x_sum;
	logic signed [19:0] grad_y_sum;
	logic [15:0]        keyline_index;

	modport source (output valid, keyline_found, limit_reached, pos_col_fx, pos_row_fx,
		grad_x_sum, grad_y_sum, keyline_index, input ready);
	modport sink (input valid, keyline_found, limit_reached, pos_col_fx, pos_row_fx,
		grad_x_sum, grad_y_sum, keyline_index, output ready);
endinterface

### design/sekd_regs.sv
// ----------------------------------------------------------------------------
// sekd_regs
// APB register file holding the detector configuration.
// ----------------------------------------------------------------------------
module sekd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sekd_pkg::ADDR_W-1:0] paddr,
	input  logic [sekd_pkg::DATA_W-1:0] pwdata,
	output logic [sekd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output sekd_pkg::cfg_t              cfg
);
	import sekd_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[ADDR_W-1:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mag_min           <= 16'd1000;
			cfg_q.grad_threshold_sq <= '0;
			cfg_q.pn_limit          <= 4'd7;
			cfg_q.keyline_limit     <= 16'd4096;
			cfg_q.image_width       <= 13'd640;
		end else if (wr) begin
			case (idx)
				REG_MAG_THR:  cfg_q.mag_min           <= pwdata[15:0];
				REG_GRAD_THR: cfg_q.grad_threshold_sq <= pwdata[39:0];
				REG_PN_LIM:   cfg_q.pn_limit          <= pwdata[3:0];
				REG_KL_LIM:   cfg_q.keyline_limit     <= pwdata[15:0];
				REG_WIDTH:    cfg_q.image_width       <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAG_THR:  prdata = {48'd0, cfg_q.mag_min};
			REG_GRAD_THR: prdata = {24'd0, cfg_q.grad_threshold_sq};
			REG_PN_LIM:   prdata = {60'd0, cfg_q.pn_limit};
			REG_KL_LIM:   prdata = {48'd0, cfg_q.keyline_limit};
			REG_WIDTH:    prdata = {51'd0, cfg_q.image_width};
			default:      prdata = '0;
		endcase
	end
endmodule

### design/sekd_ctrl.sv
// ----------------------------------------------------------------------------
// sekd_ctrl
// Sequencer of the detector: steps one pixel through sums, products,
// tests, the offset division and the result register.
// ----------------------------------------------------------------------------
module sekd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output sekd_pkg::cmd_t  cmd,
	input  sekd_pkg::stat_t st
);
	import sekd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_TST  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]     state_q, state_d;
	logic [Q_W-1:0] cnt_q;
	logic           ov_q;
	logic           fin_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign fin_ok    = (state_q == ST_FIN) && (!ov_q || out_ready);

	always_comb begin
		cmd          = '0;
		cmd.load     = in_ready && in_valid;
		cmd.sums     = (state_q == ST_SUM);
		cmd.mult     = (state_q == ST_MUL);
		cmd.test     = (state_q == ST_TST);
		cmd.div_step = (state_q == ST_DIV) && st.pass;
		cmd.finish   = fin_ok;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SUM;
			ST_SUM:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_TST;
			ST_TST:  state_d = ST_DIV;
			ST_DIV:  if (!st.pass || cnt_q == Q_W'(Q_W - 1)) state_d = ST_FIN;
			ST_FIN:  if (fin_ok) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (fin_ok) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end
endmodule

### design/sekd_dp.sv
// ----------------------------------------------------------------------------
// sekd_dp
// Datapath: window sums, plane-fit products, rejection tests, a restoring
// divider with a shared divisor for both offsets, frame counters and result register.
// ----------------------------------------------------------------------------
module sekd_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  sekd_pkg::cfg_t   cfg,
	input  sekd_pkg::pix_t   pix,
	input  sekd_pkg::cmd_t   cmd,
	output sekd_pkg::stat_t  st,
	output sekd_pkg::res_t   res
);
	import sekd_pkg::*;

	pix_t                    pix_q;
	logic signed [SUM_W-1:0] sx_q, sy_q, s_q;
	logic                    mag_ok_q, pn_ok_q;
	logic signed [PROD_W-1:0] pxx_q, pyy_q, pxs_q, pys_q;
	logic                    pass_q, negx_q, negy_q;
	logic [REM_W-1:0]        rx_q, ry_q, dsh_q;
	logic [Q_W-1:0]          qx_q, qy_q;
	logic [11:0]             col_q, row_q;
	logic [15:0]             kc_q;
	logic                    ff_q;
	res_t                    res_q;

	logic [11:0]       col_e, row_e;
	logic [15:0]       kc_e, kc_n;
	logic              ff_e, ff_n;
	logic [3:0]        npos, pdiff;
	logic [D_W-1:0]    dd, axs, ays;
	logic [PROD_W-1:0] axs_w, ays_w;
	logic [DEN_W-1:0]  den;
	logic [8:0]        xo, yo;
	logic              wrap;

	assign st.pass = pass_q;
	assign res     = res_q;

	assign col_e = pix_q.start_of_frame ? 12'd1 : col_q;
	assign row_e = pix_q.start_of_frame ? 12'd1 : row_q;
	assign kc_e  = pix_q.start_of_frame ? 16'd0 : kc_q;
	assign ff_e  = pix_q.start_of_frame ? 1'b0 : ff_q;

	always_comb begin
		npos = 4'(pix_q.dog_up_left > 0) + 4'(pix_q.dog_up > 0)
			+ 4'(pix_q.dog_up_right > 0) + 4'(pix_q.dog_left > 0)
			+ 4'(pix_q.dog_center > 0) + 4'(pix_q.dog_right > 0)
			+ 4'(pix_q.dog_down_left > 0) + 4'(pix_q.dog_down > 0)
			+ 4'(pix_q.dog_down_right > 0);
		pdiff = (npos >= 4'd5) ? 4'((npos << 1) - 4'd9) : 4'(4'd9 - (npos << 1));
	end

	always_comb begin
		dd    = pxx_q[D_W-1:0] + pyy_q[D_W-1:0];
		axs_w = pxs_q[PROD_W-1] ? 40'(-pxs_q) : pxs_q;
		ays_w = pys_q[PROD_W-1] ? 40'(-pys_q) : pys_q;
		axs   = axs_w[D_W-1:0];
		ays   = ays_w[D_W-1:0];
		den   = {2'b00, dd} + {1'b0, dd, 1'b0};
	end

	assign xo   = negx_q ? 9'(-{1'b0, qx_q}) : {1'b0, qx_q};
	assign yo   = negy_q ? 9'(-{1'b0, qy_q}) : {1'b0, qy_q};
	assign kc_n = kc_e + 16'd1;
	assign ff_n = pass_q ? ((kc_n >= cfg.keyline_limit) || (kc_n == 16'd0)) : ff_e;
	assign wrap = ({2'b00, col_e} + 14'd2 >= {1'b0, cfg.image_width}) || (col_e == 12'hFFF);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= pix;
		end
		if (cmd.sums) begin
			sx_q <= (ext_sum(pix_q.dog_up_right) + ext_sum(pix_q.dog_right)
				+ ext_sum(pix_q.dog_down_right)) - (ext_sum(pix_q.dog_up_left)
				+ ext_sum(pix_q.dog_left) + ext_sum(pix_q.dog_down_left));
			sy_q <= (ext_sum(pix_q.dog_down_left) + ext_sum(pix_q.dog_down)
				+ ext_sum(pix_q.dog_down_right)) - (ext_sum(pix_q.dog_up_left)
				+ ext_sum(pix_q.dog_up) + ext_sum(pix_q.dog_up_right));
			s_q <= ext_sum(pix_q.dog_up_left) + ext_sum(pix_q.dog_up)
				+ ext_sum(pix_q.dog_up_right) + ext_sum(pix_q.dog_left)
				+ ext_sum(pix_q.dog_center) + ext_sum(pix_q.dog_right)
				+ ext_sum(pix_q.dog_down_left) + ext_sum(pix_q.dog_down)
				+ ext_sum(pix_q.dog_down_right);
			mag_ok_q <= (pix_q.magnitude >= cfg.mag_min);
			pn_ok_q  <= (pdiff <= cfg.pn_limit);
		end
		if (cmd.mult) begin
			pxx_q <= sx_q * sx_q;
			pyy_q <= sy_q * sy_q;
			pxs_q <= sx_q * s_q;
			pys_q <= sy_q * s_q;
		end
		if (cmd.test) begin
			pass_q <= !ff_e && mag_ok_q && pn_ok_q && (dd != '0)
				&& ({axs, 2'b00} <= den) && ({ays, 2'b00} <= den)
				&& ({3'b000, dd} >= cfg.grad_threshold_sq);
			rx_q   <= {1'b0, axs, 10'd0} + {9'd0, den};
			ry_q   <= {1'b0, ays, 10'd0} + {9'd0, den};
			dsh_q  <= {1'b0, den, 8'd0};
			qx_q   <= '0;
			qy_q   <= '0;
			negx_q <= !pxs_q[PROD_W-1] && (pxs_q != '0);
			negy_q <= !pys_q[PROD_W-1] && (pys_q != '0);
		end
		if (cmd.div_step) begin
			if (rx_q >= dsh_q) begin
				rx_q <= rx_q - dsh_q;
				qx_q <= {qx_q[Q_W-2:0], 1'b1};
			end else begin
				qx_q <= {qx_q[Q_W-2:0], 1'b0};
			end
			if (ry_q >= dsh_q) begin
				ry_q <= ry_q - dsh_q;
				qy_q <= {qy_q[Q_W-2:0], 1'b1};
			end else begin
				qy_q <= {qy_q[Q_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.finish) begin
			res_q.keyline_found <= pass_q;
			res_q.limit_reached <= ff_n;
			res_q.pos_col_fx    <= pass_q ? {col_e, 8'd0} + {{11{xo[8]}}, xo} : 20'd0;
			res_q.pos_row_fx    <= pass_q ? {row_e, 8'd0} + {{11{yo[8]}}, yo} : 20'd0;
			res_q.grad_x_sum    <= sx_q;
			res_q.grad_y_sum    <= sy_q;
			res_q.keyline_index <= pass_q ? kc_e : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 12'd1;
			row_q <= 12'd1;
			kc_q  <= '0;
			ff_q  <= 1'b0;
		end else if (cmd.finish) begin
			kc_q <= pass_q ? kc_n : kc_e;
			ff_q <= ff_n;
			if (wrap) begin
				col_q <= 12'd1;
				row_q <= row_e + 12'd1;
			end else begin
				col_q <= col_e + 12'd1;
				row_q <= row_e;
			end
		end
	end
endmodule

### design/subpixel_edge_keyline_detector.sv
// ----------------------------------------------------------------------------
// subpixel_edge_keyline_detector
// Finds difference-of-Gaussian zero crossings with subpixel position.
// ----------------------------------------------------------------------------
// One pixel transaction is in work at a time: a new pixel is accepted only
// in the idle state, after the last one has left its final step. A rejected
// pixel passes the sum, product and test states and one division state with
// no divider step before its result is registered. A pixel that passes every
// test also goes through the eight-step restoring divider that forms both
// offset quotients before its result is registered. The result register lets
// the next pixel be accepted while the previous result still waits to be
// taken; the block stalls in its last step only while that result is untaken.
module subpixel_edge_keyline_detector (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sekd_pkg::ADDR_W-1:0] paddr,
	input  logic [sekd_pkg::DATA_W-1:0] pwdata,
	output logic [sekd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	sekd_in_if.sink                     in_ch,
	sekd_out_if.source                  out_ch
);
	import sekd_pkg::*;

	`include "assert_macros.svh"

	cfg_t  cfg;
	pix_t  pix;
	res_t  res;
	cmd_t  cmd;
	stat_t st;

	assign pix.start_of_frame = in_ch.start_of_frame;
	assign pix.magnitude      = in_ch.magnitude;
	assign pix.dog_up_left    = in_ch.dog_up_left;
	assign pix.dog_up         = in_ch.dog_up;
	assign pix.dog_up_right   = in_ch.dog_up_right;
	assign pix.dog_left       = in_ch.dog_left;
	assign pix.dog_center     = in_ch.dog_center;
	assign pix.dog_right      = in_ch.dog_right;
	assign pix.dog_down_left  = in_ch.dog_down_left;
	assign pix.dog_down       = in_ch.dog_down;
	assign pix.dog_down_right = in_ch.dog_down_right;

	assign out_ch.keyline_found = res.keyline_found;
	assign out_ch.limit_reached = res.limit_reached;
	assign out_ch.pos_col_fx    = res.pos_col_fx;
	assign out_ch.pos_row_fx    = res.pos_row_fx;
	assign out_ch.grad_x_sum    = res.grad_x_sum;
	assign out_ch.grad_y_sum    = res.grad_y_sum;
	assign out_ch.keyline_index = res.keyline_index;

	sekd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sekd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.st        (st)
	);

	sekd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix    (pix),
		.cmd    (cmd),
		.st     (st),
		.res    (res)
	);

	`SEKD_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready)
	`SEKD_ASSERT_SAME(a_reject_zero, out_ch.valid && !out_ch.keyline_found,
		out_ch.pos_col_fx == 20'd0 && out_ch.pos_row_fx == 20'd0 && out_ch.keyline_index == 16'd0)
	`SEKD_ASSERT_SAME(a_index_range, out_ch.valid && out_ch.keyline_found,
		out_ch.keyline_index != 16'hFFFF)
	`SEKD_ASSERT_SAME(a_ctrl_excl, cmd.load, !cmd.finish && !cmd.div_step)
endmodule

### bench/subpixel_edge_keyline_detector_tb.sv
// ----------------------------------------------------------------------------
// subpixel_edge_keyline_detector_tb
// Self-checking bench for the subpixel edge keyline detector. A directed
// table of pixels and then random frames are streamed through the block
// under several register settings. Every result is checked field by field
// against a behavioral model of the plane fit and the frame counters.
// ----------------------------------------------------------------------------
module subpixel_edge_keyline_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sekd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	sekd_in_if in_ch();
	sekd_out_if out_ch();

	subpixel_edge_keyline_detector dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("FAIL subpixel_edge_keyline_detector");
		$finish;
	end

	cfg_t cfg;
	logic [11:0] col_cnt, row_cnt;
	logic [15:0] kl_count;
	logic full;
	res_t keyline_q[$];
	int errors = 0;
	int pixels_sent = 0;
	int results_seen = 0;
	int keylines_seen = 0;
	int hold_cycles = 0;
	bit sink_idle_free = 1'b0;
	bit src_idle_free = 1'b0;

	typedef struct {
		pix_t pix;
		bit   typed;
		res_t want;
	} row_t;

	function automatic longint unsigned absl(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned q;
		q = (2 * absl(num) + den) / (2 * den);
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic res_t detect_keyline(pix_t p);
		longint win[9];
		longint sx, sy, s, dd, xo, yo;
		int npos;
		res_t r;
		win = '{p.dog_up_left, p.dog_up, p.dog_up_right, p.dog_left, p.dog_center,
			p.dog_right, p.dog_down_left, p.dog_down, p.dog_down_right};
		r = '0;
		if (p.start_of_frame) begin
			col_cnt = 1;
			row_cnt = 1;
			kl_count = 0;
			full = 1'b0;
		end
		npos = 0;
		s = 0;
		foreach (win[i]) begin
			if (win[i] > 0)
				npos++;
			s += win[i];
		end
		sx = (win[2] + win[5] + win[8]) - (win[0] + win[3] + win[6]);
		sy = (win[6] + win[7] + win[8]) - (win[0] + win[1] + win[2]);
		dd = sx * sx + sy * sy;
		if (!full && p.magnitude >= cfg.mag_min
				&& absl(2 * npos - 9) <= cfg.pn_limit && dd != 0
				&& 4 * absl(sx * s) <= 3 * dd && 4 * absl(sy * s) <= 3 * dd
				&& dd >= longint'(cfg.grad_threshold_sq)) begin
			xo = round_div(-512 * sx * s, 3 * dd);
			yo = round_div(-512 * sy * s, 3 * dd);
			r.keyline_found = 1'b1;
			r.pos_col_fx = 20'(longint'(col_cnt) * 256 + xo);
			r.pos_row_fx = 20'(longint'(row_cnt) * 256 + yo);
			r.keyline_index = kl_count;
			kl_count = kl_count + 16'd1;
			if (kl_count >= cfg.keyline_limit || kl_count == 0)
				full = 1'b1;
		end
		r.limit_reached = full;
		r.grad_x_sum = 20'(sx);
		r.grad_y_sum = 20'(sy);
		if (longint'(col_cnt) >= longint'(cfg.image_width) - 2 || col_cnt >= 12'd4095) begin
			col_cnt = 1;
			row_cnt = row_cnt + 12'd1;
		end else begin
			col_cnt = col_cnt + 12'd1;
		end
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 3;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MAG_THR:  cfg.mag_min = val[15:0];
			REG_GRAD_THR: cfg.grad_threshold_sq = val[39:0];
			REG_PN_LIM:   cfg.pn_limit = val[3:0];
			REG_KL_LIM:   cfg.keyline_limit = val[15:0];
			REG_WIDTH:    cfg.image_width = val[12:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (keyline_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (30) @(posedge clk);
	endtask

	task automatic send_pixel(pix_t p, bit typed, res_t want);
		res_t r;
		@(negedge clk);
		if (!src_idle_free)
			while ($urandom_range(99) < 9)
				@(negedge clk);
		in_ch.valid <= 1'b1;
		{in_ch.start_of_frame, in_ch.magnitude, in_ch.dog_up_left, in_ch.dog_up,
			in_ch.dog_up_right, in_ch.dog_left, in_ch.dog_center, in_ch.dog_right,
			in_ch.dog_down_left, in_ch.dog_down, in_ch.dog_down_right} <= p;
		do @(posedge clk); while (!in_ch.ready);
		r = detect_keyline(p);
		if (typed && r != want) begin
			$display("%0t table row mismatch: expected %h actual model %h", $time, want, r);
			errors++;
		end
		keyline_q.push_back(r);
		pixels_sent++;
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// A window tuned so that the plane crosses zero near the center.
	function automatic pix_t edge_pixel(bit sof);
		pix_t p;
		int g, off;
		g = $urandom_range(4000, 1);
		off = int'($urandom_range(2 * g)) - g;
		p.start_of_frame = sof;
		p.magnitude = 16'($urandom_range(65535));
		p.dog_up_left = 16'(-g + off);
		p.dog_left = 16'(-g + off);
		p.dog_down_left = 16'(-g + off);
		p.dog_up = 16'(off + int'($urandom_range(20)) - 10);
		p.dog_center = 16'(off);
		p.dog_down = 16'(off + int'($urandom_range(20)) - 10);
		p.dog_up_right = 16'(g + off);
		p.dog_right = 16'(g + off);
		p.dog_down_right = 16'(g + off + int'($urandom_range(20)) - 10);
		if ($urandom_range(1)) begin
			p.dog_up_left = 16'(-g + off);
			p.dog_up = 16'(-g + off);
			p.dog_up_right = 16'(-g + off);
			p.dog_left = 16'(off);
			p.dog_right = 16'(off + int'($urandom_range(20)) - 10);
			p.dog_down_left = 16'(g + off);
			p.dog_down = 16'(g + off);
		end
		return p;
	endfunction

	function automatic pix_t noise_pixel(bit sof);
		pix_t p;
		p = pix_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		p.start_of_frame = sof;
		return p;
	endfunction

	function automatic pix_t flat_pixel(logic [15:0] mag, logic [15:0] v, bit sof);
		pix_t p;
		p = '{sof, mag, v, v, v, v, v, v, v, v, v};
		return p;
	endfunction

	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.keyline_found, out_ch.limit_reached, out_ch.pos_col_fx,
				out_ch.pos_row_fx, out_ch.grad_x_sum, out_ch.grad_y_sum,
				out_ch.keyline_index};
			results_seen++;
			if (got.keyline_found)
				keylines_seen++;
			if (keyline_q.size() == 0) begin
				$display("%0t unexpected result transaction: actual %h", $time, got);
				errors++;
			end else begin
				want = keyline_q.pop_front();
				if (got.keyline_found !== want.keyline_found
						|| got.limit_reached !== want.limit_reached
						|| got.pos_col_fx !== want.pos_col_fx
						|| got.pos_row_fx !== want.pos_row_fx
						|| got.grad_x_sum !== want.grad_x_sum
						|| got.grad_y_sum !== want.grad_y_sum
						|| got.keyline_index !== want.keyline_index) begin
					$display("%0t result mismatch: expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ch.ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ch.ready <= sink_idle_free || ($urandom_range(99) >= 9);
		end
	end

	initial begin
		row_t dir[$];
		res_t none;
		pix_t p;
		int n;
		in_ch.valid = 1'b0;
		{in_ch.start_of_frame, in_ch.magnitude, in_ch.dog_up_left, in_ch.dog_up,
			in_ch.dog_up_right, in_ch.dog_left, in_ch.dog_center, in_ch.dog_right,
			in_ch.dog_down_left, in_ch.dog_down, in_ch.dog_down_right} = '0;
		out_ch.ready = 1'b0;
		cfg = '{16'd1000, 40'd0, 4'd7, 16'd4096, 13'd640};
		col_cnt = 1;
		row_cnt = 1;
		kl_count = 0;
		full = 1'b0;
		none = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, reset settings.
		dir.push_back('{flat_pixel(16'd0, 16'd0, 1'b1), 1'b1, none});
		dir.push_back('{flat_pixel(16'hFFFF, 16'h7FFF, 1'b0), 1'b1,
			'{1'b0, 1'b0, 20'd0, 20'd0, 20'sd0, 20'sd0, 16'd0}});
		dir.push_back('{flat_pixel(16'hFFFF, 16'h8000, 1'b0), 1'b1, none});
		p = flat_pixel(16'd999, 16'd0, 1'b0);
		p.dog_right = 16'sd100;
		p.dog_left = -16'sd100;
		dir.push_back('{p, 1'b1, '{1'b0, 1'b0, 20'd0, 20'd0, 20'sd200, 20'sd0, 16'd0}});
		p.magnitude = 16'd1000;
		dir.push_back('{p, 1'b0, none});
		p = flat_pixel(16'hFFFF, 16'h8000, 1'b0);
		{p.dog_up_right, p.dog_right, p.dog_down_right} = {3{16'h7FFF}};
		dir.push_back('{p, 1'b0, none});
		{p.dog_up_left, p.dog_up, p.dog_up_right} = {3{16'h7FFF}};
		{p.dog_down_left, p.dog_down, p.dog_down_right} = {3{16'h8000}};
		dir.push_back('{p, 1'b0, none});
		for (int i = 0; i < 14; i++)
			dir.push_back('{edge_pixel(1'b0), 1'b0, none});
		foreach (dir[i])
			send_pixel(dir[i].pix, dir[i].typed, dir[i].want);
		drain();

		// Random phases over several settings, extremes included.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_MAG_THR, 64'd0);
					write_reg(REG_GRAD_THR, 64'd0);
					write_reg(REG_PN_LIM, 64'd9);
					write_reg(REG_KL_LIM, 64'd65535);
					write_reg(REG_WIDTH, 64'd3);
				end
				1: begin
					write_reg(REG_KL_LIM, 64'd1);
					write_reg(REG_WIDTH, 64'd4096);
					write_reg(REG_PN_LIM, 64'd0);
				end
				2: begin
					write_reg(REG_KL_LIM, 64'd0);
					write_reg(REG_PN_LIM, 64'd9);
					write_reg(REG_GRAD_THR, 64'hFF_FFFF_FFFF);
					write_reg(REG_MAG_THR, 64'd65535);
				end
				3: begin
					write_reg(REG_GRAD_THR, 64'd40000);
					write_reg(REG_MAG_THR, 64'd30000);
					write_reg(REG_KL_LIM, 64'd5);
					write_reg(REG_WIDTH, 64'd9);
				end
				4: begin
					write_reg(REG_MAG_THR, 64'd0);
					write_reg(REG_GRAD_THR, 64'd0);
					write_reg(REG_KL_LIM, 64'd20);
					write_reg(REG_WIDTH, 64'd3000);
				end
				default: begin
					write_reg(REG_PN_LIM, 64'd3);
					write_reg(REG_KL_LIM, 64'd4096);
					write_reg(REG_WIDTH, 64'd17);
				end
			endcase
			src_idle_free = (ph == 4);
			sink_idle_free = (ph == 4);
			n = (ph == 0 || ph == 2) ? 200 : 360;
			for (int i = 0; i < n; i++) begin
				if (ph == 1 && i == 100)
					hold_cycles = 300;
				if ($urandom_range(99) < 80)
					send_pixel(edge_pixel($urandom_range(99) < 3), 1'b0, none);
				else
					send_pixel(noise_pixel($urandom_range(99) < 3), 1'b0, none);
			end
			drain();
		end

		if (keyline_q.size() != 0) begin
			$display("%0t %0d result transactions never arrived", $time, keyline_q.size());
			errors++;
		end
		$display("Run covered %0d pixel transactions, %0d results, %0d keylines found.",
			pixels_sent, results_seen, keylines_seen);
		if (errors == 0)
			$display("PASS subpixel_edge_keyline_detector");
		else
			$display("FAIL subpixel_edge_keyline_detector");
		$finish;
	end
endmodule
